// File: rtl/iir_filter_direct_form_one_macros.svh
`ifndef IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define IIRDF1_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent check that also holds across reset.
`define IIRDF1_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/iirdf1_pkg.sv
package iirdf1_pkg;

   localparam int COEF_BITS      = 18;
   localparam int FRAC_SHIFT     = 16;
   localparam int CHAN_BITS      = 3;
   localparam int NUM_COEFS      = 5;
   localparam int CSR_INDEX_BITS = 3;

   localparam int DEFAULT_TAPS         = 3;
   localparam int DEFAULT_MAX_CHANNELS = 8;
   localparam int DEFAULT_SAMPLE_BITS  = 24;

   // Slots of the coefficient set; feedback slots come last and are subtracted.
   localparam int SLOT_FF0 = 0;
   localparam int SLOT_FF1 = 1;
   localparam int SLOT_FF2 = 2;
   localparam int SLOT_FB1 = 3;
   localparam int SLOT_FB2 = 4;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   localparam coef_type COEF_ONE  = coef_type'(65536);
   localparam coef_type COEF_ZERO = coef_type'(0);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FF_COEF_0       = 3'd0,
      CSR_FF_COEF_1       = 3'd1,
      CSR_FF_COEF_2       = 3'd2,
      CSR_FB_COEF_1       = 3'd3,
      CSR_FB_COEF_2       = 3'd4,
      CSR_LEAD_GAIN_RECIP = 3'd5
   } csr_index_type;

   // Delay tap that a coefficient slot belongs to.
   function automatic int coef_tap(input int slot);
      int tap;
      case (slot)
         SLOT_FF0: tap = 0;
         SLOT_FF1, SLOT_FB1: tap = 1;
         default: tap = 2;
      endcase
      return tap;
   endfunction

endpackage

// File: rtl/iirdf1_channels.sv
interface iirdf1_req_if #(
   parameter int SAMPLE_BITS = iirdf1_pkg::DEFAULT_SAMPLE_BITS
);
   import iirdf1_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_sample;
   logic [CHAN_BITS-1:0]          chan_index;

   modport source (output valid, output in_sample, output chan_index, input ready);
   modport sink   (input valid, input in_sample, input chan_index, output ready);
endinterface

interface iirdf1_rsp_if #(
   parameter int SAMPLE_BITS = iirdf1_pkg::DEFAULT_SAMPLE_BITS
);
   import iirdf1_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic [CHAN_BITS-1:0]          out_chan;
   logic                          clipped;

   modport source (output valid, output out_sample, output out_chan, output clipped,
                   input ready);
   modport sink   (input valid, input out_sample, input out_chan, input clipped,
                   output ready);
endinterface

// File: rtl/iirdf1_hist.sv
module iirdf1_hist #(
   parameter int MAX_CHANNELS = iirdf1_pkg::DEFAULT_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = iirdf1_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [iirdf1_pkg::CHAN_BITS-1:0]    rd_chan,
   output logic                                rd_ok,
   output logic signed [SAMPLE_BITS-1:0]       rd_x1,
   output logic signed [SAMPLE_BITS-1:0]       rd_x2,
   output logic signed [SAMPLE_BITS-1:0]       rd_y1,
   output logic signed [SAMPLE_BITS-1:0]       rd_y2,
   input  logic                                wr_en,
   input  logic [iirdf1_pkg::CHAN_BITS-1:0]    wr_chan,
   input  logic signed [SAMPLE_BITS-1:0]       wr_x0,
   input  logic signed [SAMPLE_BITS-1:0]       wr_x1,
   input  logic signed [SAMPLE_BITS-1:0]       wr_y0,
   input  logic signed [SAMPLE_BITS-1:0]       wr_y1
);
   import iirdf1_pkg::*;

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W = CHAN_BITS + IDX_W;

   logic [CMP_W-1:0] rd_wide;
   logic [CMP_W-1:0] wr_wide;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic             rd_live;

   logic signed [SAMPLE_BITS-1:0] x1_ff [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x1_in [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x2_ff [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x2_in [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y1_ff [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y1_in [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y2_ff [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y2_in [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]       live_ff;
   logic [MAX_CHANNELS-1:0]       live_in;

   assign rd_wide = CMP_W'(rd_chan);
   assign wr_wide = CMP_W'(wr_chan);
   assign rd_idx  = rd_wide[IDX_W-1:0];
   assign wr_idx  = wr_wide[IDX_W-1:0];
   assign rd_ok   = rd_wide < CMP_W'(MAX_CHANNELS);

   // A channel that has never been written reads as all-zero history.
   assign rd_live = rd_ok && live_ff[rd_idx];
   assign rd_x1   = rd_live ? x1_ff[rd_idx] : '0;
   assign rd_x2   = rd_live ? x2_ff[rd_idx] : '0;
   assign rd_y1   = rd_live ? y1_ff[rd_idx] : '0;
   assign rd_y2   = rd_live ? y2_ff[rd_idx] : '0;

   always_comb begin
      x1_in   = x1_ff;
      x2_in   = x2_ff;
      y1_in   = y1_ff;
      y2_in   = y2_ff;
      live_in = live_ff;
      if (wr_en) begin
         x1_in[wr_idx]   = wr_x0;
         x2_in[wr_idx]   = wr_x1;
         y1_in[wr_idx]   = wr_y0;
         y2_in[wr_idx]   = wr_y1;
         live_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      y1_ff <= y1_in;
      y2_ff <= y2_in;
   end

endmodule

// File: rtl/iirdf1_serial_mac.sv
module iirdf1_serial_mac #(
   parameter int TAPS        = iirdf1_pkg::DEFAULT_TAPS,
   parameter int SAMPLE_BITS = iirdf1_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] x0,
   input  logic signed [SAMPLE_BITS-1:0] x1,
   input  logic signed [SAMPLE_BITS-1:0] x2,
   input  logic signed [SAMPLE_BITS-1:0] y1,
   input  logic signed [SAMPLE_BITS-1:0] y2,
   input  iirdf1_pkg::coef_type          coefs [iirdf1_pkg::NUM_COEFS],
   input  iirdf1_pkg::coef_type          gain,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] result,
   output logic                          clip
);
   import iirdf1_pkg::*;

   localparam int PART_W = SAMPLE_BITS + 3;
   localparam int T_W    = SAMPLE_BITS + 4;
   localparam int ACC_W  = SAMPLE_BITS + 22;
   localparam int Y_W    = ACC_W - FRAC_SHIFT;
   localparam int CNT_W  = $clog2(COEF_BITS);

   localparam logic [CNT_W-1:0]          LAST_BIT   = CNT_W'(COEF_BITS - 1);
   localparam logic signed [ACC_W-1:0]   HALF_LSB   = ACC_W'(1) <<< (FRAC_SHIFT - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ACC   = 6'b000010,
      ST_RND1  = 6'b000100,
      ST_SCALE = 6'b001000,
      ST_RND2  = 6'b010000,
      ST_DONE  = 6'b100000
   } mac_state_type;

   mac_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [SAMPLE_BITS-1:0] samp_ff    [NUM_COEFS];
   logic signed [SAMPLE_BITS-1:0] samp_in    [NUM_COEFS];
   coef_type                      coef_sr_ff [NUM_COEFS];
   coef_type                      coef_sr_in [NUM_COEFS];
   coef_type                      gain_sr_ff, gain_sr_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [T_W-1:0]         t_ff, t_in;
   logic signed [SAMPLE_BITS-1:0] result_ff, result_in;
   logic                          clip_ff, clip_in;

   logic signed [PART_W-1:0] part;
   logic signed [ACC_W-1:0]  gain_term;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  addend_signed;
   logic signed [ACC_W-1:0]  step_sum;
   logic signed [ACC_W-1:0]  rounded;
   logic [Y_W-1:0]           rounded_hi;
   logic                     fits;

   // One coefficient bit per cycle, MSB first, for all five products at once.
   always_comb begin
      part = '0;
      for (int i = 0; i < NUM_COEFS; i++) begin
         if (coef_sr_ff[i][COEF_BITS-1]) begin
            if (i < SLOT_FB1) begin
               part = part + PART_W'(samp_ff[i]);
            end else begin
               part = part - PART_W'(samp_ff[i]);
            end
         end
      end
   end

   assign gain_term = gain_sr_ff[COEF_BITS-1] ? ACC_W'(t_ff) : '0;
   assign addend    = (state_ff == ST_SCALE) ? gain_term : ACC_W'(part);
   // The multiplier MSB carries negative weight in two's complement.
   assign addend_signed = (cnt_ff == '0) ? -addend : addend;
   assign step_sum      = (acc_ff <<< 1) + addend_signed;

   // Round to nearest with ties upward: add half an LSB, then floor.
   assign rounded    = acc_ff + HALF_LSB;
   assign rounded_hi = rounded[ACC_W-1:FRAC_SHIFT];
   assign fits       = (&rounded_hi[Y_W-1:SAMPLE_BITS-1]) ||
                       !(|rounded_hi[Y_W-1:SAMPLE_BITS-1]);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      samp_in    = samp_ff;
      coef_sr_in = coef_sr_ff;
      gain_sr_in = gain_sr_ff;
      acc_in     = acc_ff;
      t_in       = t_ff;
      result_in  = result_ff;
      clip_in    = clip_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (start) begin
               samp_in[SLOT_FF0] = x0;
               samp_in[SLOT_FF1] = x1;
               samp_in[SLOT_FF2] = x2;
               samp_in[SLOT_FB1] = y1;
               samp_in[SLOT_FB2] = y2;
               for (int i = 0; i < NUM_COEFS; i++) begin
                  coef_sr_in[i] = (coef_tap(i) < TAPS) ? coefs[i] : COEF_ZERO;
               end
               gain_sr_in = gain;
               acc_in     = '0;
               cnt_in     = '0;
               state_in   = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in = step_sum;
            for (int i = 0; i < NUM_COEFS; i++) begin
               coef_sr_in[i] = coef_sr_ff[i] << 1;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_BIT) begin
               cnt_in   = '0;
               state_in = ST_RND1;
            end
         end
         ST_RND1: begin
            t_in     = $signed(rounded_hi[T_W-1:0]);
            acc_in   = '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            acc_in     = step_sum;
            gain_sr_in = gain_sr_ff << 1;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_BIT) begin
               cnt_in   = '0;
               state_in = ST_RND2;
            end
         end
         ST_RND2: begin
            if (fits) begin
               result_in = $signed(rounded_hi[SAMPLE_BITS-1:0]);
               clip_in   = 1'b0;
            end else begin
               result_in = rounded_hi[Y_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
               clip_in   = 1'b1;
            end
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff    <= samp_in;
      coef_sr_ff <= coef_sr_in;
      gain_sr_ff <= gain_sr_in;
      acc_ff     <= acc_in;
      t_ff       <= t_in;
      result_ff  <= result_in;
      clip_ff    <= clip_in;
   end

   assign done   = (state_ff == ST_DONE);
   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

// File: rtl/iir_filter_direct_form_one.sv
// Channel     Direction  Handshake            Payload
// req_chan    in         valid/ready          in_sample, chan_index
// rsp_chan    out        valid/ready          out_sample, out_chan, clipped
// csr_*       in         csr_write_enable     csr_index, csr_write_data
//
// One request is in flight at a time; the next can be accepted once the previous result
// has reached the output register. The serial multiplier forms the five-term sum, one
// bit of every coefficient per cycle, rounds it, then applies the gain one bit per cycle.
// Reset (synchronous, active high) loads unity gain and empties every channel history.
// A stalled result holds in the output register while the next request is taken; a
// further result then waits in the multiplier until that register frees.
module iir_filter_direct_form_one #(
   parameter int TAPS         = iirdf1_pkg::DEFAULT_TAPS,
   parameter int MAX_CHANNELS = iirdf1_pkg::DEFAULT_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = iirdf1_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   iirdf1_req_if.sink                            req_chan,
   iirdf1_rsp_if.source                          rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [iirdf1_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [iirdf1_pkg::COEF_BITS-1:0]      csr_write_data
);
   import iirdf1_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } top_state_type;

   top_state_type state_ff, state_in;

   coef_type coef_ff [NUM_COEFS];
   coef_type coef_in [NUM_COEFS];
   coef_type gain_ff, gain_in;

   logic [CHAN_BITS-1:0]          chan_ff, chan_in;
   logic                          ok_ff, ok_in;
   logic signed [SAMPLE_BITS-1:0] x0_ff, x0_in;
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CHAN_BITS-1:0]          rsp_chan_ff, rsp_chan_in;
   logic                          rsp_clip_ff, rsp_clip_in;

   logic                          rd_ok;
   logic signed [SAMPLE_BITS-1:0] rd_x1, rd_x2, rd_y1, rd_y2;
   logic                          mac_done;
   logic signed [SAMPLE_BITS-1:0] mac_result;
   logic                          mac_clip;
   logic                          accept;
   logic                          out_free;
   logic                          finish;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign finish         = (state_ff == ST_BUSY) && mac_done && out_free;

   always_comb begin
      coef_in = coef_ff;
      gain_in = gain_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FF_COEF_0:       coef_in[SLOT_FF0] = coef_type'(csr_write_data);
            CSR_FF_COEF_1:       coef_in[SLOT_FF1] = coef_type'(csr_write_data);
            CSR_FF_COEF_2:       coef_in[SLOT_FF2] = coef_type'(csr_write_data);
            CSR_FB_COEF_1:       coef_in[SLOT_FB1] = coef_type'(csr_write_data);
            CSR_FB_COEF_2:       coef_in[SLOT_FB2] = coef_type'(csr_write_data);
            CSR_LEAD_GAIN_RECIP: gain_in           = coef_type'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      ok_in    = ok_ff;
      x0_in    = x0_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chan_in  = req_chan.chan_index;
               ok_in    = rd_ok;
               x0_in    = req_chan.in_sample;
               x1_in    = rd_x1;
               y1_in    = rd_y1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_clip_in   = rsp_clip_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = mac_result;
         rsp_chan_in   = chan_ff;
         rsp_clip_in   = mac_clip;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= (i == SLOT_FF0) ? COEF_ONE : COEF_ZERO;
         end
         gain_ff <= COEF_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         gain_ff      <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff       <= chan_in;
      ok_ff         <= ok_in;
      x0_ff         <= x0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_sample = rsp_sample_ff;
   assign rsp_chan.out_chan   = rsp_chan_ff;
   assign rsp_chan.clipped    = rsp_clip_ff;

   // Out-of-range channels run on zero history and leave every history untouched.
   iirdf1_hist #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_chan (req_chan.chan_index),
      .rd_ok   (rd_ok),
      .rd_x1   (rd_x1),
      .rd_x2   (rd_x2),
      .rd_y1   (rd_y1),
      .rd_y2   (rd_y2),
      .wr_en   (finish && ok_ff),
      .wr_chan (chan_ff),
      .wr_x0   (x0_ff),
      .wr_x1   (x1_ff),
      .wr_y0   (mac_result),
      .wr_y1   (y1_ff)
   );

   iirdf1_serial_mac #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .x0     (req_chan.in_sample),
      .x1     (rd_x1),
      .x2     (rd_x2),
      .y1     (rd_y1),
      .y2     (rd_y2),
      .coefs  (coef_ff),
      .gain   (gain_ff),
      .done   (mac_done),
      .result (mac_result),
      .clip   (mac_clip)
   );

endmodule

// File: rtl/iirdf1_checker.sv
`include "iir_filter_direct_form_one_macros.svh"

module iirdf1_checker #(
   parameter int SAMPLE_BITS = iirdf1_pkg::DEFAULT_SAMPLE_BITS
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [SAMPLE_BITS-1:0]         rsp_out_sample,
   input logic [iirdf1_pkg::CHAN_BITS-1:0] rsp_out_chan,
   input logic                           rsp_clipped
);
   import iirdf1_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   `IIRDF1_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample) && $stable(rsp_out_chan) && $stable(rsp_clipped), "stalled result changed")
   `IIRDF1_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")
   `IIRDF1_ASSERT(a_clip_at_rail, clock, reset, rsp_valid && rsp_clipped |-> (rsp_out_sample == SAMPLE_MAX) || (rsp_out_sample == SAMPLE_MIN), "clipped sample not at full scale")
   `IIRDF1_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind iir_filter_direct_form_one iirdf1_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_iirdf1_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_sample (rsp_chan.out_sample),
   .rsp_out_chan   (rsp_chan.out_chan),
   .rsp_clipped    (rsp_chan.clipped)
);

// File: sim/iir_filter_direct_form_one_tb.sv
module iir_filter_direct_form_one_tb;
   import iirdf1_pkg::*;

   localparam int SAMPLE_BITS     = DEFAULT_SAMPLE_BITS;
   localparam int MAX_CHANNELS    = DEFAULT_MAX_CHANNELS;
   localparam int IDLE_PERCENT    = 37;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int STEADY_PHASE    = 4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type           sample;
      logic [CHAN_BITS-1:0] chan;
      logic                 clip;
   } filtered_sample_type;

   typedef enum int {STYLE_WIDE, STYLE_GENTLE, STYLE_EXTREME} coef_style_type;

   localparam sample_type SAMPLE_MAX = sample_type'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
   localparam sample_type SAMPLE_MIN = sample_type'(-(longint'(1) << (SAMPLE_BITS - 1)));
   localparam coef_type   COEF_MAX   = coef_type'(131071);
   localparam coef_type   COEF_MIN   = coef_type'(-131072);
   localparam coef_type   COEF_HALF  = coef_type'(32768);
   localparam longint     ROUND_HALF = longint'(1) << (FRAC_SHIFT - 1);

   // Indexes past the last register; writes there must leave the filter unchanged.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_7 = 3'd7;

   localparam sample_type CORNER[8] = '{SAMPLE_MAX, SAMPLE_MIN, sample_type'(0),
                                        sample_type'(1), sample_type'(-1),
                                        sample_type'(24'h555555), sample_type'(24'hAAAAAA),
                                        sample_type'(24'h000100)};

   class filter_scoreboard;
      coef_type            coef[NUM_COEFS];
      coef_type            gain;
      sample_type          x_hist[MAX_CHANNELS][2];
      sample_type          y_hist[MAX_CHANNELS][2];
      filtered_sample_type pending[$];
      int                  mismatches;
      int                  clipped_count;
      int                  checked;

      function new();
         coef[SLOT_FF0] = COEF_ONE;
         coef[SLOT_FF1] = COEF_ZERO;
         coef[SLOT_FF2] = COEF_ZERO;
         coef[SLOT_FB1] = COEF_ZERO;
         coef[SLOT_FB2] = COEF_ZERO;
         gain = COEF_ONE;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            x_hist[c] = '{sample_type'(0), sample_type'(0)};
            y_hist[c] = '{sample_type'(0), sample_type'(0)};
         end
      endfunction

      function void set_coef(logic [CSR_INDEX_BITS-1:0] index, coef_type value);
         case (index)
            CSR_FF_COEF_0:       coef[SLOT_FF0] = value;
            CSR_FF_COEF_1:       coef[SLOT_FF1] = value;
            CSR_FF_COEF_2:       coef[SLOT_FF2] = value;
            CSR_FB_COEF_1:       coef[SLOT_FB1] = value;
            CSR_FB_COEF_2:       coef[SLOT_FB2] = value;
            CSR_LEAD_GAIN_RECIP: gain = value;
            default: ;
         endcase
      endfunction

      function void note_input(sample_type x, logic [CHAN_BITS-1:0] ch);
         longint              acc;
         longint              scaled;
         longint              y;
         sample_type          x1;
         sample_type          x2;
         sample_type          y1;
         sample_type          y2;
         bit                  known;
         filtered_sample_type r;
         known = ch < MAX_CHANNELS;
         x1 = known ? x_hist[ch][0] : sample_type'(0);
         x2 = known ? x_hist[ch][1] : sample_type'(0);
         y1 = known ? y_hist[ch][0] : sample_type'(0);
         y2 = known ? y_hist[ch][1] : sample_type'(0);
         acc = longint'(coef[SLOT_FF0]) * longint'(x)
             + longint'(coef[SLOT_FF1]) * longint'(x1)
             - longint'(coef[SLOT_FB1]) * longint'(y1)
             + longint'(coef[SLOT_FF2]) * longint'(x2)
             - longint'(coef[SLOT_FB2]) * longint'(y2);
         // Both roundings are to nearest with ties going up: add half, then floor.
         scaled = (acc + ROUND_HALF) >>> FRAC_SHIFT;
         y = (scaled * longint'(gain) + ROUND_HALF) >>> FRAC_SHIFT;
         r.clip = 1'b0;
         if (y > longint'(SAMPLE_MAX)) begin
            y = longint'(SAMPLE_MAX);
            r.clip = 1'b1;
         end else if (y < longint'(SAMPLE_MIN)) begin
            y = longint'(SAMPLE_MIN);
            r.clip = 1'b1;
         end
         r.sample = sample_type'(y);
         r.chan = ch;
         if (known) begin
            x_hist[ch] = '{x, x1};
            y_hist[ch] = '{r.sample, y1};
         end
         if (r.clip)
            clipped_count++;
         pending = {pending, r};
      endfunction

      function void check_result(sample_type s, logic [CHAN_BITS-1:0] ch, logic clip);
         filtered_sample_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result sample %0d chan %0d clipped %0b",
                     $time, s, ch, clip);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (s !== want.sample) begin
            $display("%0t: out_sample expected %0d, got %0d", $time, want.sample, s);
            mismatches++;
         end
         if (ch !== want.chan) begin
            $display("%0t: out_chan expected %0d, got %0d", $time, want.chan, ch);
            mismatches++;
         end
         if (clip !== want.clip) begin
            $display("%0t: clipped expected %0b, got %0b", $time, want.clip, clip);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COEF_BITS-1:0]      csr_write_data;
   bit                        steady = 1'b0;
   int                        quiet_cycles = 0;

   filter_scoreboard sb = new();

   iirdf1_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   iirdf1_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   iir_filter_direct_form_one #(
      .TAPS(DEFAULT_TAPS),
      .MAX_CHANNELS(MAX_CHANNELS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit idle_now();
      return !steady && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return sample_type'(int'($urandom_range(2000)) - 1000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_type pick_coef(coef_style_type style, csr_index_type r);
      case (style)
         STYLE_EXTREME: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
         STYLE_GENTLE: begin
            if (r == CSR_LEAD_GAIN_RECIP)
               return $urandom_range(1) ? COEF_ONE : coef_type'($urandom_range(98304, 32768));
            if (r == CSR_FB_COEF_1 || r == CSR_FB_COEF_2)
               return coef_type'(int'($urandom_range(32768)) - 16384);
            return coef_type'(int'($urandom_range(65536)) - 32768);
         end
         default: return coef_type'($urandom);
      endcase
   endfunction

   // The receiver stalls at random; ready changes only on the falling edge.
   always @(negedge clock)
      rsp_if.ready <= !idle_now();

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.out_sample, rsp_if.out_chan, rsp_if.clipped);
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_sample(input sample_type x, input logic [CHAN_BITS-1:0] ch);
      @(negedge clock);
      while (idle_now()) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_sample <= x;
      req_if.chan_index <= ch;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      sb.note_input(x, ch);
   endtask

   // Registers may only change once every outstanding result has come back.
   task automatic drain_filter();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input coef_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_coef(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic randomize_filter(input coef_style_type style);
      csr_index_type r;
      r = r.first();
      do begin
         if (style == STYLE_EXTREME || $urandom_range(3) != 0)
            write_reg(r, pick_coef(style, r));
         r = r.next();
      end while (r != r.first());
   endtask

   initial begin
      int chan_span;
      int settings;
      req_if.valid <= 1'b0;
      req_if.in_sample <= '0;
      req_if.chan_index <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Unity pass-through after reset: field extremes on every channel.
      for (int i = 0; i < 8; i++)
         send_sample(CORNER[i], CHAN_BITS'(i));

      // Halfway values in the accumulator rounding.
      drain_filter();
      write_reg(CSR_FF_COEF_0, COEF_HALF);
      send_sample(sample_type'(1), CHAN_BITS'(1));
      send_sample(sample_type'(-1), CHAN_BITS'(1));
      send_sample(sample_type'(3), CHAN_BITS'(6));
      send_sample(sample_type'(-3), CHAN_BITS'(6));

      // Halfway values in the gain rounding.
      drain_filter();
      write_reg(CSR_FF_COEF_0, COEF_ONE);
      write_reg(CSR_LEAD_GAIN_RECIP, COEF_HALF);
      send_sample(sample_type'(1), CHAN_BITS'(2));
      send_sample(sample_type'(-1), CHAN_BITS'(2));

      // Extreme coefficients drive saturation both ways; spare indexes are ignored.
      drain_filter();
      write_reg(CSR_FF_COEF_0, COEF_MAX);
      write_reg(CSR_FF_COEF_1, COEF_MIN);
      write_reg(CSR_FF_COEF_2, COEF_MAX);
      write_reg(CSR_FB_COEF_1, COEF_MIN);
      write_reg(CSR_FB_COEF_2, COEF_MAX);
      write_reg(CSR_LEAD_GAIN_RECIP, COEF_MAX);
      write_reg(CSR_SPARE_6, COEF_ZERO);
      write_reg(CSR_SPARE_7, COEF_MIN);
      send_sample(SAMPLE_MAX, CHAN_BITS'(5));
      send_sample(SAMPLE_MIN, CHAN_BITS'(5));
      send_sample(SAMPLE_MAX, CHAN_BITS'(5));
      send_sample(sample_type'(0), CHAN_BITS'(5));
      send_sample(SAMPLE_MIN, CHAN_BITS'(5));
      send_sample(SAMPLE_MAX, CHAN_BITS'(5));
      settings = 4;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_filter();
         randomize_filter(coef_style_type'(phase % 3));
         settings++;
         steady = (phase == STEADY_PHASE);
         // Some phases stay on two channels so their histories run long.
         chan_span = $urandom_range(1) ? MAX_CHANNELS - 1 : 1;
         repeat (ITEMS_PER_PHASE)
            send_sample(pick_sample(), CHAN_BITS'($urandom_range(chan_span)));
      end

      drain_filter();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Filtered %0d samples over %0d coefficient settings; %0d came out clipped.",
               sb.checked, settings, sb.clipped_count);
      $display("Mismatches: %0d, results still outstanding: %0d.",
               sb.mismatches, sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
